>>> design/celp_pkg.sv
package celp_pkg;

    typedef enum logic [9:0] {
        PH_I          = 10'b00_0000_0001,
        PH_M          = 10'b00_0000_0010,
        PH_G          = 10'b00_0000_0100,
        PH_PRE_NUM    = 10'b00_0000_1000,
        PH_SIGN       = 10'b00_0001_0000,
        PH_DIGITS     = 10'b00_0010_0000,
        PH_PRE_COLON  = 10'b00_0100_0000,
        PH_PRE_LETTER = 10'b00_1000_0000,
        PH_DONE       = 10'b01_0000_0000,
        PH_FAIL       = 10'b10_0000_0000
    } phase_t;

    typedef logic [1:0] status_t;
    localparam status_t ST_STORED     = 2'd0;
    localparam status_t ST_BAD_LENGTH = 2'd1;
    localparam status_t ST_BAD_FORMAT = 2'd2;
    localparam status_t ST_OUT_RANGE  = 2'd3;

    typedef logic [1:0] event_t;
    localparam event_t EV_NONE  = 2'd0;
    localparam event_t EV_FIRE  = 2'd1;
    localparam event_t EV_SMOKE = 2'd2;

    localparam logic CMD_CHAR  = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    localparam logic [5:0] MIN_LINE_LEN = 6'd13;
    localparam logic [5:0] MAX_LINE_LEN = 6'd17;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_LOW_I   = 8'h69;
    localparam logic [7:0] CH_LOW_M   = 8'h6D;
    localparam logic [7:0] CH_LOW_G   = 8'h67;
    localparam logic [7:0] CH_F       = 8'h46;
    localparam logic [7:0] CH_S       = 8'h53;
    localparam logic [7:0] CH_N       = 8'h4E;

    localparam int OUT_FRAMES = 16;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

>>> design/camera_event_line_parser.sv
// Channel | Handshake                  | Contents (lowest bit first)
// s_      | s_tvalid / s_tready        | s_tdata: char_byte; s_tuser: command
// m_      | m_tvalid / m_tready        | m_tlast: line_done; m_tdata: line_status,
//         |                            |   frame_id, event_code, all_ready,
//         |                            |   ready_mask, packed_events
// One character is parsed per cycle while the output is not stalled; its result is registered.
// The parser state and frame table update in the same cycle, so items can follow back to back.
// A single output register holds the result; input is taken whenever it is empty or being read.
// Reset returns the line parser and frame table to their cleared state with no clearing pass.
// A stall on the result side stalls the input side in the same cycle.
module camera_event_line_parser
    import celp_pkg::*;
#(
    parameter int NUM_FRAMES       = 16,
    parameter int LINE_BUFFER_SIZE = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_byte
    input  logic        s_tuser,   // [0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [1:0] line_status, [5:2] frame_id,
                                   // [7:6] event_code, [8] all_ready,
                                   // [24:9] ready_mask, [56:25] packed_events
    output logic        m_tlast    // line_done
);

    logic                  capturing_reg, capturing_next;
    logic [5:0]            line_length_reg, line_length_next;
    phase_t                phase_reg, phase_next;
    logic [15:0]           accum_reg, accum_next;
    logic                  negative_reg, negative_next;
    logic                  overflow_reg, overflow_next;
    logic [7:0]            letter_reg, letter_next;
    logic [NUM_FRAMES-1:0] frame_ready_reg, frame_ready_next;
    event_t                frame_events_reg [NUM_FRAMES];
    event_t                frame_events_next [NUM_FRAMES];

    logic        m_tvalid_reg;
    logic [63:0] m_tdata_reg;
    logic        m_tlast_reg;

    logic        accept;
    logic        done;
    status_t     status;
    logic [3:0]  fnum;
    event_t      ecode;
    logic [15:0] mask_out;
    logic [31:0] packed_out;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    always_comb begin
        logic [7:0]  c;
        logic        cap;
        logic [5:0]  len;
        logic [19:0] product;
        logic        take_digit;
        c          = s_tdata;
        cap        = capturing_reg;
        len        = line_length_reg;
        take_digit = 1'b0;
        product    = '0;

        capturing_next    = capturing_reg;
        line_length_next  = line_length_reg;
        phase_next        = phase_reg;
        accum_next        = accum_reg;
        negative_next     = negative_reg;
        overflow_next     = overflow_reg;
        letter_next       = letter_reg;
        frame_ready_next  = frame_ready_reg;
        frame_events_next = frame_events_reg;
        done   = 1'b0;
        status = ST_STORED;
        fnum   = '0;
        ecode  = EV_NONE;

        if (s_tuser == CMD_CLEAR) begin
            capturing_next   = 1'b0;
            line_length_next = '0;
            phase_next       = PH_I;
            accum_next       = '0;
            negative_next    = 1'b0;
            overflow_next    = 1'b0;
            letter_next      = '0;
            frame_ready_next = '0;
            for (int f = 0; f < NUM_FRAMES; f++) begin
                frame_events_next[f] = EV_NONE;
            end
        end else begin
            if (c == CH_LOW_I) begin
                cap = 1'b1;
            end
            capturing_next = cap;
            if (cap) begin
                len = line_length_reg + 6'd1;
                line_length_next = len;
                if (phase_reg != PH_DONE && phase_reg != PH_FAIL) begin
                    if (c == CH_NUL) begin
                        phase_next = PH_FAIL;
                    end else begin
                        unique case (phase_reg)
                            PH_I: begin
                                phase_next = (c == CH_LOW_I) ? PH_M : PH_FAIL;
                            end
                            PH_M: begin
                                phase_next = (c == CH_LOW_M) ? PH_G : PH_FAIL;
                            end
                            PH_G: begin
                                phase_next = (c == CH_LOW_G) ? PH_PRE_NUM : PH_FAIL;
                            end
                            PH_PRE_NUM: begin
                                if (is_space(c)) begin
                                    phase_next = PH_PRE_NUM;
                                end else if (c == CH_PLUS || c == CH_MINUS) begin
                                    negative_next = (c == CH_MINUS);
                                    phase_next    = PH_SIGN;
                                end else if (is_digit(c)) begin
                                    take_digit = 1'b1;
                                    phase_next = PH_DIGITS;
                                end else begin
                                    phase_next = PH_FAIL;
                                end
                            end
                            PH_SIGN: begin
                                if (is_digit(c)) begin
                                    take_digit = 1'b1;
                                    phase_next = PH_DIGITS;
                                end else begin
                                    phase_next = PH_FAIL;
                                end
                            end
                            PH_DIGITS: begin
                                if (is_digit(c)) begin
                                    take_digit = 1'b1;
                                end else if (is_space(c)) begin
                                    phase_next = PH_PRE_COLON;
                                end else if (c == CH_COLON) begin
                                    phase_next = PH_PRE_LETTER;
                                end else begin
                                    phase_next = PH_FAIL;
                                end
                            end
                            PH_PRE_COLON: begin
                                if (!is_space(c)) begin
                                    phase_next = (c == CH_COLON) ? PH_PRE_LETTER : PH_FAIL;
                                end
                            end
                            PH_PRE_LETTER: begin
                                if (!is_space(c)) begin
                                    letter_next = c;
                                    phase_next  = PH_DONE;
                                end
                            end
                            default: begin
                                phase_next = PH_FAIL;
                            end
                        endcase
                    end
                end
                if (take_digit && !overflow_reg) begin
                    product = {1'b0, accum_reg, 3'b000} + {3'b000, accum_reg, 1'b0}
                              + {12'd0, c - CH_ZERO};
                    if (product > 20'h0FFFF) begin
                        overflow_next = 1'b1;
                    end else begin
                        accum_next = product[15:0];
                    end
                end
            end

            if (c == CH_NEWLINE) begin
                done = 1'b1;
                if (!cap || len < MIN_LINE_LEN || len > MAX_LINE_LEN) begin
                    status = ST_BAD_LENGTH;
                end else if (phase_next != PH_DONE ||
                             (letter_next != CH_F && letter_next != CH_S &&
                              letter_next != CH_N)) begin
                    status = ST_BAD_FORMAT;
                end else begin
                    fnum = accum_next[3:0];
                    if (overflow_next || (negative_next && accum_next != '0) ||
                        {16'd0, accum_next} >= 32'(NUM_FRAMES)) begin
                        status = ST_OUT_RANGE;
                    end else begin
                        ecode = (letter_next == CH_F) ? EV_FIRE :
                                (letter_next == CH_S) ? EV_SMOKE : EV_NONE;
                        for (int f = 0; f < NUM_FRAMES; f++) begin
                            if (accum_next == 16'(f)) begin
                                frame_events_next[f] = ecode;
                                frame_ready_next[f]  = 1'b1;
                            end
                        end
                    end
                end
            end

            if (c == CH_NEWLINE || len >= 6'(LINE_BUFFER_SIZE)) begin
                capturing_next   = 1'b0;
                line_length_next = '0;
                phase_next       = PH_I;
                accum_next       = '0;
                negative_next    = 1'b0;
                overflow_next    = 1'b0;
                letter_next      = '0;
            end
        end
    end

    for (genvar g = 0; g < OUT_FRAMES; g++) begin : g_out
        if (g < NUM_FRAMES) begin : g_used
            assign mask_out[g]           = frame_ready_next[g];
            assign packed_out[2*g +: 2]  = frame_events_next[g];
        end else begin : g_unused
            assign mask_out[g]           = 1'b0;
            assign packed_out[2*g +: 2]  = 2'b00;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capturing_reg   <= 1'b0;
            line_length_reg <= '0;
            phase_reg       <= PH_I;
            accum_reg       <= '0;
            negative_reg    <= 1'b0;
            overflow_reg    <= 1'b0;
            letter_reg      <= '0;
            frame_ready_reg <= '0;
            for (int f = 0; f < NUM_FRAMES; f++) begin
                frame_events_reg[f] <= EV_NONE;
            end
            m_tvalid_reg    <= 1'b0;
        end else begin
            if (accept) begin
                capturing_reg    <= capturing_next;
                line_length_reg  <= line_length_next;
                phase_reg        <= phase_next;
                accum_reg        <= accum_next;
                negative_reg     <= negative_next;
                overflow_reg     <= overflow_next;
                letter_reg       <= letter_next;
                frame_ready_reg  <= frame_ready_next;
                frame_events_reg <= frame_events_next;
                m_tvalid_reg     <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tlast_reg <= done;
            m_tdata_reg <= {7'd0, packed_out, mask_out, &frame_ready_next, ecode, fnum, status};
        end
    end

    // A stored line must show its frame as ready in the same transaction.
    a_stored_sets_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast && m_tdata[1:0] == ST_STORED) |-> m_tdata[9 + m_tdata[5:2]])
        else $error("stored line without ready flag");

    // Outside a line end, the line fields are zero.
    a_idle_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> (m_tdata[7:0] == 8'd0))
        else $error("line fields set without line end");

    // Length only counts while a line is being captured.
    a_length_needs_capture: assert property (@(posedge aclk) disable iff (!aresetn)
        !capturing_reg |-> (line_length_reg == '0))
        else $error("line length nonzero while idle");

    // An abandoned line never keeps a length at the buffer size.
    a_length_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        line_length_reg < 6'(LINE_BUFFER_SIZE))
        else $error("line length reached buffer size");

    // A clear command empties the ready flags.
    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tuser == CMD_CLEAR) |=> (frame_ready_reg == '0))
        else $error("ready flags survive clear");

endmodule
